@@ rtl/tcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Typesetter command decoder package
// Shared types, command codes and the point-size table.
// ----------------------------------------------------------------------------
package tcd_pkg;

  localparam int POS_BITS_DEFAULT = 24;
  localparam int OUT_POS_W        = 24;
  localparam int CORR_UNITS       = 55;
  localparam int START_ROW        = 25;
  localparam logic [5:0] SIZE_RESET = 6'd10;

  // Control command codes.
  localparam logic [7:0] CMD_JOB      = 8'o100;
  localparam logic [7:0] CMD_RAIL_LO  = 8'o101;
  localparam logic [7:0] CMD_RAIL_HI  = 8'o102;
  localparam logic [7:0] CMD_MAG_HI   = 8'o103;
  localparam logic [7:0] CMD_MAG_LO   = 8'o104;
  localparam logic [7:0] CMD_LOWER    = 8'o105;
  localparam logic [7:0] CMD_UPPER    = 8'o106;
  localparam logic [7:0] CMD_ESC_FWD  = 8'o107;
  localparam logic [7:0] CMD_ESC_BACK = 8'o110;
  localparam logic [7:0] CMD_LEAD_FWD = 8'o112;
  localparam logic [7:0] CMD_LEAD_BACK = 8'o114;

  localparam logic [3:0] SIZE_DOUBLE_FIRST = 4'd9;

  typedef enum logic [2:0] {
    EV_GLYPH    = 3'd0,
    EV_RAIL_MAG = 3'd1,
    EV_SIZE     = 3'd2,
    EV_START    = 3'd3,
    EV_STOP     = 3'd4
  } event_kind_t;

  typedef struct packed {
    event_kind_t                  kind;
    logic [6:0]                   char_code;
    logic [1:0]                   rail_mag;
    logic [5:0]                   point_size;
    logic                         size_invalid;
    logic signed [OUT_POS_W-1:0]  row_pos;
    logic signed [OUT_POS_W-1:0]  col_pos;
  } result_t;

  // Point size for a 4-bit size code; zero marks a code with no entry.
  function automatic logic [5:0] size_lookup(input logic [3:0] code);
    logic [5:0] pts;
    case (code)
      4'd0:    pts = 6'd7;
      4'd1:    pts = 6'd8;
      4'd2:    pts = 6'd10;
      4'd3:    pts = 6'd11;
      4'd4:    pts = 6'd12;
      4'd5:    pts = 6'd14;
      4'd6:    pts = 6'd18;
      4'd7:    pts = 6'd9;
      4'd8:    pts = 6'd6;
      4'd9:    pts = 6'd16;
      4'd10:   pts = 6'd20;
      4'd11:   pts = 6'd22;
      4'd12:   pts = 6'd24;
      4'd13:   pts = 6'd28;
      4'd14:   pts = 6'd36;
      default: pts = 6'd0;
    endcase
    return pts;
  endfunction

endpackage

@@ rtl/tcd_core.sv @@
// ----------------------------------------------------------------------------
// Typesetter command decoder core
// Holds the typesetter state; decodes one command byte per cycle of advance.
// ----------------------------------------------------------------------------
module tcd_core import tcd_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] cmd,
  output logic       has_result,
  output result_t    result
);

  logic [POS_BITS-1:0] pending_escape, pending_escape_next;
  logic                escape_backward, escape_backward_next;
  logic                lead_backward, lead_backward_next;
  logic                upper_case, upper_case_next;
  logic [1:0]          font_select, font_select_next;
  logic [POS_BITS-1:0] row_now, row_now_next;
  logic [POS_BITS-1:0] col_now, col_now_next;
  logic                double_size, double_size_next;
  logic [5:0]          size_now, size_now_next;
  logic                started, started_next;
  logic                stopped, stopped_next;

  logic [POS_BITS-1:0]           col_moved;
  logic [6:0]                    lead_step;
  logic [5:0]                    pts;
  logic                          dbl;
  logic                          corr_en;
  logic                          corr_neg;
  event_kind_t                   kind;
  logic [6:0]                    ch;
  logic                          inval;
  logic [POS_BITS+OUT_POS_W-1:0] row_ext;
  logic [POS_BITS+OUT_POS_W-1:0] col_ext;

  // Any non-escape byte that is not ignored commits pending motion to the column.
  assign col_moved = escape_backward ? (col_now - pending_escape)
                                     : (col_now + pending_escape);
  assign lead_step = {2'b00, ~cmd[4:0]} + {1'b0, ~cmd[4:0], 1'b0};
  assign pts       = size_lookup(cmd[3:0]);
  assign dbl       = (cmd[3:0] >= SIZE_DOUBLE_FIRST);
  assign corr_en   = (dbl != double_size);
  assign corr_neg  = (dbl & ~double_size) ^ escape_backward;

  always_comb begin
    pending_escape_next  = pending_escape;
    escape_backward_next = escape_backward;
    lead_backward_next   = lead_backward;
    upper_case_next      = upper_case;
    font_select_next     = font_select;
    row_now_next         = row_now;
    col_now_next         = col_now;
    double_size_next     = double_size;
    size_now_next        = size_now;
    started_next         = started;
    stopped_next         = stopped;
    has_result           = 1'b0;
    kind                 = EV_GLYPH;
    ch                   = 7'd0;
    inval                = 1'b0;

    if (stopped || cmd == 8'd0) begin
      // Ignored byte.
    end else if (cmd[7]) begin
      pending_escape_next = pending_escape + {{(POS_BITS-7){1'b0}}, ~cmd[6:0]};
    end else begin
      col_now_next        = col_moved;
      pending_escape_next = '0;
      if (cmd[7:6] == 2'b00) begin
        has_result = 1'b1;
        kind       = EV_GLYPH;
        ch         = {upper_case, cmd[5:0]};
      end else begin
        case (cmd)
          CMD_JOB: begin
            has_result = 1'b1;
            if (started) begin
              stopped_next = 1'b1;
              kind         = EV_STOP;
            end else begin
              started_next         = 1'b1;
              row_now_next         = POS_BITS'(START_ROW);
              col_now_next         = '0;
              lead_backward_next   = 1'b0;
              escape_backward_next = 1'b0;
              upper_case_next      = 1'b0;
              font_select_next     = 2'b00;
              kind                 = EV_START;
            end
          end
          CMD_RAIL_LO: begin
            font_select_next = {font_select[1], 1'b0};
            has_result       = 1'b1;
            kind             = EV_RAIL_MAG;
          end
          CMD_RAIL_HI: begin
            font_select_next = {font_select[1], 1'b1};
            has_result       = 1'b1;
            kind             = EV_RAIL_MAG;
          end
          CMD_MAG_HI: begin
            font_select_next = {1'b1, font_select[0]};
            has_result       = 1'b1;
            kind             = EV_RAIL_MAG;
          end
          CMD_MAG_LO: begin
            font_select_next = {1'b0, font_select[0]};
            has_result       = 1'b1;
            kind             = EV_RAIL_MAG;
          end
          CMD_LOWER:     upper_case_next      = 1'b0;
          CMD_UPPER:     upper_case_next      = 1'b1;
          CMD_ESC_FWD:   escape_backward_next = 1'b0;
          CMD_ESC_BACK:  escape_backward_next = 1'b1;
          CMD_LEAD_FWD:  lead_backward_next   = 1'b0;
          CMD_LEAD_BACK: lead_backward_next   = 1'b1;
          default: begin
            if (cmd inside {[8'o140:8'o177]}) begin
              if (lead_backward) begin
                row_now_next = row_now - {{(POS_BITS-7){1'b0}}, lead_step};
              end else begin
                row_now_next = row_now + {{(POS_BITS-7){1'b0}}, lead_step};
              end
            end else if (cmd inside {[8'o120:8'o137]}) begin
              has_result = 1'b1;
              kind       = EV_SIZE;
              if (pts == 6'd0) begin
                inval = 1'b1;
              end else begin
                // The pending motion was just committed, so the size
                // correction becomes the whole pending motion.
                if (corr_en) begin
                  pending_escape_next = corr_neg ? -POS_BITS'(CORR_UNITS)
                                                 : POS_BITS'(CORR_UNITS);
                end
                double_size_next = dbl;
                size_now_next    = pts;
              end
            end
          end
        endcase
      end
    end
  end

  assign row_ext = {{OUT_POS_W{1'b0}}, row_now_next};
  assign col_ext = {{OUT_POS_W{1'b0}}, col_now_next};

  always_comb begin
    result.kind         = kind;
    result.char_code    = ch;
    result.rail_mag     = font_select_next;
    result.point_size   = size_now_next;
    result.size_invalid = inval;
    result.row_pos      = row_ext[OUT_POS_W-1:0];
    result.col_pos      = col_ext[OUT_POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_escape  <= '0;
      escape_backward <= 1'b0;
      lead_backward   <= 1'b0;
      upper_case      <= 1'b0;
      font_select     <= 2'b00;
      row_now         <= '0;
      col_now         <= '0;
      double_size     <= 1'b0;
      size_now        <= SIZE_RESET;
      started         <= 1'b0;
      stopped         <= 1'b0;
    end else if (advance) begin
      pending_escape  <= pending_escape_next;
      escape_backward <= escape_backward_next;
      lead_backward   <= lead_backward_next;
      upper_case      <= upper_case_next;
      font_select     <= font_select_next;
      row_now         <= row_now_next;
      col_now         <= col_now_next;
      double_size     <= double_size_next;
      size_now        <= size_now_next;
      started         <= started_next;
      stopped         <= stopped_next;
    end
  end

  a_stopped_silent: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !has_result)
    else $error("decoder produced a result after job stop");

  a_stop_needs_start: assert property (@(posedge clk) disable iff (rst)
    stopped |-> started)
    else $error("job stopped without having started");

  a_size_known: assert property (@(posedge clk) disable iff (rst)
    advance && has_result && result.size_invalid |=> $stable(size_now))
    else $error("unknown size code changed the point size");

endmodule

@@ rtl/tcd_out_reg.sv @@
// ----------------------------------------------------------------------------
// Typesetter command decoder result register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module tcd_out_reg import tcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    valid,
  input  logic    ready,
  output result_t data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

@@ rtl/typesetter_command_decoder_top.sv @@
// ----------------------------------------------------------------------------
// Typesetter command decoder
// Decodes a phototypesetter command byte stream into glyph and control events.
// ----------------------------------------------------------------------------
// Each command byte is captured in an input register, decoded against the
// current typesetter state, and any event it causes is placed in a result
// register. One byte is taken every cycle; the only stall comes from a full
// result register whose event is not being taken, and bytes that cause no
// event (escapes, leading, case and direction codes) pass through even then.
// An event reaches the output from the result register. Positions are tracked
// at POS_BITS and reported as 24 bits.
module typesetter_command_decoder_top import tcd_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   cmd_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   event_kind,
  output logic [6:0]                   char_code,
  output logic [1:0]                   rail_mag,
  output logic [5:0]                   point_size,
  output logic                         size_invalid,
  output logic signed [OUT_POS_W-1:0]  row_pos,
  output logic signed [OUT_POS_W-1:0]  col_pos
);

  logic       ib_valid;
  logic [7:0] ib_byte;
  logic       has_result;
  logic       advance;
  result_t    core_result;
  result_t    out_data;

  // A byte leaves the input register when its event, if any, has room.
  assign advance  = ib_valid && (!has_result || !out_valid || out_ready);
  assign in_ready = !ib_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (in_ready) begin
      ib_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib_byte <= cmd_byte;
    end
  end

  tcd_core #(
    .POS_BITS(POS_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .cmd        (ib_byte),
    .has_result (has_result),
    .result     (core_result)
  );

  tcd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .load_data (core_result),
    .valid     (out_valid),
    .ready     (out_ready),
    .data      (out_data)
  );

  assign event_kind   = out_data.kind;
  assign char_code    = out_data.char_code;
  assign rail_mag     = out_data.rail_mag;
  assign point_size   = out_data.point_size;
  assign size_invalid = out_data.size_invalid;
  assign row_pos      = out_data.row_pos;
  assign col_pos      = out_data.col_pos;

  a_event_lands: assert property (@(posedge clk) disable iff (rst)
    advance && has_result |=> out_valid)
    else $error("decoded event did not reach the result register");

endmodule

@@ test/tcd_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typesetter command decoder event checker
// Watches both channels of the decoder, tracks the typesetter state from the
// accepted command bytes, and compares every event the decoder reports, field
// by field, with the oldest predicted event.
// ----------------------------------------------------------------------------
module tcd_event_checker import tcd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [7:0]                  cmd_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [2:0]                  event_kind,
  input  logic [6:0]                  char_code,
  input  logic [1:0]                  rail_mag,
  input  logic [5:0]                  point_size,
  input  logic                        size_invalid,
  input  logic signed [OUT_POS_W-1:0] row_pos,
  input  logic signed [OUT_POS_W-1:0] col_pos,
  output int                          errors,
  output int                          outstanding
);

  localparam int PW           = POS_BITS_DEFAULT;
  localparam int REPORT_LIMIT = 10;
  localparam logic [2:0] LEAD_PREFIX = 3'b011;
  localparam logic [3:0] SIZE_PREFIX = 4'b0101;

  // Points per size code, code 15 first; zero means the code has no size.
  localparam logic [15:0][5:0] SIZE_POINTS = {
    6'd0, 6'd36, 6'd28, 6'd24, 6'd22, 6'd20, 6'd16, 6'd6,
    6'd9, 6'd18, 6'd14, 6'd12, 6'd11, 6'd10, 6'd8, 6'd7
  };

  logic [PW-1:0] esc_pending;
  logic          esc_back;
  logic          lead_back;
  logic          upper;
  logic [1:0]    font;
  logic [PW-1:0] row;
  logic [PW-1:0] col;
  logic          in_double;
  logic [5:0]    size_now;
  logic          job_started;
  logic          job_stopped;

  result_t expected_events [$];
  result_t want;
  int      mismatches = 0;

  assign errors = mismatches;

  function automatic result_t snapshot(event_kind_t kind, logic [6:0] ch, logic inval);
    result_t r;
    r.kind         = kind;
    r.char_code    = ch;
    r.rail_mag     = font;
    r.point_size   = size_now;
    r.size_invalid = inval;
    r.row_pos      = row[OUT_POS_W-1:0];
    r.col_pos      = col[OUT_POS_W-1:0];
    return r;
  endfunction

  task automatic decode_command(input logic [7:0] b);
    logic [6:0]    esc7;
    logic [4:0]    lead5;
    logic [PW-1:0] lift;
    logic [PW-1:0] corr;
    logic [5:0]    pts;
    logic          to_double;
    if (job_stopped || b == 8'd0) return;
    if (b[7]) begin
      esc7 = ~b[6:0];
      esc_pending = esc_pending + PW'(esc7);
      return;
    end
    // Any other byte first settles the motion collected from escapes.
    if (esc_pending != '0) begin
      col = esc_back ? col - esc_pending : col + esc_pending;
      esc_pending = '0;
    end
    if (b < CMD_JOB) begin
      expected_events.push_back(snapshot(EV_GLYPH, {upper, b[5:0]}, 1'b0));
      return;
    end
    case (b)
      CMD_JOB: begin
        if (job_started) begin
          job_stopped = 1'b1;
          expected_events.push_back(snapshot(EV_STOP, '0, 1'b0));
        end else begin
          job_started = 1'b1;
          row         = PW'(START_ROW);
          col         = '0;
          esc_pending = '0;
          lead_back   = 1'b0;
          esc_back    = 1'b0;
          upper       = 1'b0;
          font        = '0;
          expected_events.push_back(snapshot(EV_START, '0, 1'b0));
        end
      end
      CMD_RAIL_LO: begin
        font[0] = 1'b0;
        expected_events.push_back(snapshot(EV_RAIL_MAG, '0, 1'b0));
      end
      CMD_RAIL_HI: begin
        font[0] = 1'b1;
        expected_events.push_back(snapshot(EV_RAIL_MAG, '0, 1'b0));
      end
      CMD_MAG_HI: begin
        font[1] = 1'b1;
        expected_events.push_back(snapshot(EV_RAIL_MAG, '0, 1'b0));
      end
      CMD_MAG_LO: begin
        font[1] = 1'b0;
        expected_events.push_back(snapshot(EV_RAIL_MAG, '0, 1'b0));
      end
      CMD_LOWER:     upper = 1'b0;
      CMD_UPPER:     upper = 1'b1;
      CMD_ESC_FWD:   esc_back = 1'b0;
      CMD_ESC_BACK:  esc_back = 1'b1;
      CMD_LEAD_FWD:  lead_back = 1'b0;
      CMD_LEAD_BACK: lead_back = 1'b1;
      default: begin
        if (b[7:5] == LEAD_PREFIX) begin
          lead5 = ~b[4:0];
          lift  = PW'(lead5) * PW'(3);
          row   = lead_back ? row - lift : row + lift;
        end else if (b[7:4] == SIZE_PREFIX) begin
          pts = SIZE_POINTS[b[3:0]];
          if (pts == 6'd0) begin
            expected_events.push_back(snapshot(EV_SIZE, '0, 1'b1));
          end else begin
            to_double = (b[3:0] >= SIZE_DOUBLE_FIRST);
            corr = '0;
            if (in_double != to_double) corr = PW'(CORR_UNITS);
            // Entering the double range pulls the column back.
            if (to_double) corr = -corr;
            if (esc_back) corr = -corr;
            esc_pending = esc_pending + corr;
            in_double   = to_double;
            size_now    = pts;
            expected_events.push_back(snapshot(EV_SIZE, '0, 1'b0));
          end
        end
      end
    endcase
  endtask

  function automatic void check_field(string name, logic [31:0] wanted, logic [31:0] got);
    if (got !== wanted) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s expected %0h, got %0h", $time, name, wanted, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      esc_pending = '0;
      esc_back    = 1'b0;
      lead_back   = 1'b0;
      upper       = 1'b0;
      font        = '0;
      row         = '0;
      col         = '0;
      in_double   = 1'b0;
      size_now    = SIZE_RESET;
      job_started = 1'b0;
      job_stopped = 1'b0;
      expected_events.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: event kind %0d reported with no request waiting", $time, event_kind);
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", want.kind, event_kind);
          check_field("char_code", want.char_code, char_code);
          check_field("rail_mag", want.rail_mag, rail_mag);
          check_field("point_size", want.point_size, point_size);
          check_field("size_invalid", want.size_invalid, size_invalid);
          check_field("row_pos", want.row_pos, row_pos);
          check_field("col_pos", want.col_pos, col_pos);
        end
      end
      if (in_valid && in_ready) decode_command(cmd_byte);
    end
    outstanding <= expected_events.size();
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typesetter command decoder testbench
// Feeds directed and random command bytes under varying backpressure and
// leaves the event comparison to the checker; reports the final verdict.
// ----------------------------------------------------------------------------
module tb import tcd_pkg::*; ();

  localparam int ITEMS       = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 5000;
  localparam logic [7:0] CMD_SPARE_A = 8'o111;
  localparam logic [7:0] CMD_SPARE_B = 8'o113;
  localparam logic [2:0] LEAD_PREFIX = 3'b011;
  localparam logic [3:0] SIZE_PREFIX = 4'b0101;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic [7:0] cmd_byte = 8'd0;
  logic out_ready = 1'b0;

  logic                        in_ready;
  logic                        out_valid;
  logic [2:0]                  event_kind;
  logic [6:0]                  char_code;
  logic [1:0]                  rail_mag;
  logic [5:0]                  point_size;
  logic                        size_invalid;
  logic signed [OUT_POS_W-1:0] row_pos;
  logic signed [OUT_POS_W-1:0] col_pos;

  int errors;
  int outstanding;
  int tx_idle_pct  = 8;
  int rx_idle_pct  = 47;
  int holds_asked  = 0;
  int holds_served = 0;
  int quiet_cycles = 0;

  // Opening sequence: escapes of both extremes, an unknown size, a move into
  // the double range escaping forward and out of it escaping backward, then job
  // start, every rail and magazine code and the codes with no effect.
  logic [7:0] opening [26] = '{
    8'h00, 8'h3F, 8'hFF, 8'h80, 8'h01, 8'h5F, 8'h5E, CMD_UPPER, 8'h3F,
    CMD_ESC_BACK, CMD_LEAD_BACK, 8'h60, 8'h7F, 8'h81, 8'h50, 8'h20,
    CMD_JOB, CMD_RAIL_HI, CMD_MAG_HI, CMD_RAIL_LO, CMD_MAG_LO,
    CMD_SPARE_A, CMD_SPARE_B, CMD_LOWER, CMD_ESC_FWD, CMD_LEAD_FWD
  };

  always #2 clk = ~clk;

  typesetter_command_decoder_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd_byte(cmd_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_kind(event_kind), .char_code(char_code), .rail_mag(rail_mag),
    .point_size(point_size), .size_invalid(size_invalid),
    .row_pos(row_pos), .col_pos(col_pos)
  );

  tcd_event_checker event_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd_byte(cmd_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_kind(event_kind), .char_code(char_code), .rail_mag(rail_mag),
    .point_size(point_size), .size_invalid(size_invalid),
    .row_pos(row_pos), .col_pos(col_pos),
    .errors(errors), .outstanding(outstanding)
  );

  // The second job code would end the run early, so it is kept out here.
  function automatic logic [7:0] random_command();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 40)      b = {2'b00, 6'($urandom_range(63, 1))};
    else if (pick < 55) b = {1'b1, 7'($urandom_range(127))};
    else if (pick < 65) b = {LEAD_PREFIX, 5'($urandom_range(31))};
    else if (pick < 77) b = {SIZE_PREFIX, 4'($urandom_range(15))};
    else if (pick < 89) b = 8'($urandom_range(CMD_LEAD_BACK + 8'd3, CMD_RAIL_LO));
    else if (pick < 94) b = 8'd0;
    else                b = 8'($urandom);
    if (b == CMD_JOB) b = CMD_UPPER;
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input bit with_hold);
    int done;
    logic [7:0] b;
    done = 0;
    while (done < count) begin
      b = random_command();
      if (with_hold && done == 50) begin
        holds_asked++;
        with_hold = 1'b0;
      end
      send_byte(b);
      if (b != 8'd0) done++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (opening[i]) send_byte(opening[i]);
    run_phase(ITEMS / 3, 1'b0);
    drain();
    tx_idle_pct = 47;
    rx_idle_pct = 8;
    run_phase(ITEMS / 3, 1'b0);
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(ITEMS - 2 * (ITEMS / 3), 1'b1);
    // Stop the job; everything after it must be ignored.
    send_byte(CMD_JOB);
    send_byte(8'h05);
    send_byte(CMD_JOB);
    send_byte(CMD_RAIL_HI);
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    @(posedge clk);
    forever begin
      if (holds_served != holds_asked) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
